// ----- design/otm_pkg.sv -----
// Shared types, constants and helpers for the oligo Tm / weight calculator.
package otm_pkg;

    localparam int CNT_W  = 12;             // base counters
    localparam int MW_W   = 21;             // weight accumulator
    localparam int DIV_W  = 25;             // dividend and quotient of the shared divider
    localparam int DVR_W  = 21;             // divisor of the shared divider
    localparam int TMQ_W  = 17;             // quotient of 67500 / N
    localparam int TM_W   = 14;
    localparam int GC_W   = 7;
    localparam int OD_W   = 18;
    localparam int WT_W   = 9;              // per-base weight
    localparam int CALC_W = 15;             // Tm arithmetic

    localparam logic [CNT_W-1:0]  MAX_BASES    = 12'd4095;
    localparam logic [CNT_W-1:0]  TM_MIN_BASES = 12'd14;
    localparam logic [CNT_W-1:0]  TM_WAL_MAX   = 12'd20;
    localparam logic [MW_W-1:0]   MW_CORR      = 21'd61;
    localparam logic [DIV_W-1:0]  GC_SCALE     = 25'd100;
    localparam logic [DIV_W-1:0]  TM_NUM       = 25'd67500;
    localparam logic [DIV_W-1:0]  OD_NUM       = 25'd33000000;
    localparam logic [CALC_W-1:0] TM_SLOPE     = 15'd41;
    localparam logic [CALC_W-1:0] TM_OFFSET    = 15'd8150;
    localparam logic [CALC_W-1:0] WAL_SCALE    = 15'd100;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;

    localparam logic [WT_W-1:0] WT_A = 9'd312;
    localparam logic [WT_W-1:0] WT_C = 9'd288;
    localparam logic [WT_W-1:0] WT_G = 9'd328;
    localparam logic [WT_W-1:0] WT_T = 9'd303;

    typedef struct packed {
        logic [7:0] base_char;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic              empty_seq;
        logic              overflow;
        logic [CNT_W-1:0]  base_count;
        logic [GC_W-1:0]   gc_percent;
        logic [TM_W-1:0]   tm_centi;
        logic [MW_W-1:0]   mol_weight;
        logic [OD_W-1:0]   od_amount;
    } t_out_word;

    typedef enum logic [1:0] {
        DIV_GC = 2'd0,
        DIV_TM = 2'd1,
        DIV_OD = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     div_start;
        t_div_sel div_sel;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic empty;
    } t_dp_stat;

    // weight of a base character, zero for anything that is not a base
    function automatic logic [WT_W-1:0] base_weight(input logic [7:0] ch);
        logic [WT_W-1:0] w;
        w = '0;
        unique case (ch)
            CH_A:    w = WT_A;
            CH_C:    w = WT_C;
            CH_G:    w = WT_G;
            CH_T:    w = WT_T;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- design/otm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module otm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [otm_pkg::DIV_W-1:0]  i_dividend,
    input  logic [otm_pkg::DVR_W-1:0]  i_divisor,
    output logic [otm_pkg::DIV_W-1:0]  o_quot,
    output logic                       o_done
);
    import otm_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_dvd;       // dividend shifting out, quotient shifting in
    logic [DVR_W-1:0]  r_dvr;
    logic [DVR_W:0]    r_rem;
    logic [STEP_W-1:0] r_cnt;
    logic              r_active;
    logic              r_done;

    logic [DVR_W:0]    w_trial;
    logic              w_fit;

    always_comb begin
        w_trial = {r_rem[DVR_W-1:0], r_dvd[DIV_W-1]};
        w_fit   = (w_trial >= {1'b0, r_dvr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= STEP_W'(DIV_W);
            end else if (r_active) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvr <= i_divisor;
            r_rem <= '0;
        end else if (r_active) begin
            r_rem <= w_fit ? (w_trial - {1'b0, r_dvr}) : w_trial;
            r_dvd <= {r_dvd[DIV_W-2:0], w_fit};
        end
    end

    assign o_quot = r_dvd;
    assign o_done = r_done;

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_active) else $error("divider done while still stepping");

endmodule

// ----- design/otm_dp.sv -----
// Datapath: base counters, weight accumulator, shared divider and result register.
module otm_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  otm_pkg::t_in_word  i_word,
    input  otm_pkg::t_dp_cmd   i_cmd,
    output otm_pkg::t_dp_stat  o_stat,
    output logic               o_done,
    output otm_pkg::t_out_word o_word
);
    import otm_pkg::*;

    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_cnt_gc;
    logic [MW_W-1:0]  r_mw_acc;
    logic             r_ovf;
    logic [GC_W-1:0]  r_gc_pct;
    logic [TMQ_W-1:0] r_tm_q;
    logic [OD_W-1:0]  r_od;
    logic             r_done;
    t_out_word        r_word;

    logic [WT_W-1:0]   w_wt;
    logic              w_is_gc;
    logic [MW_W-1:0]   w_mw;
    logic [DIV_W-1:0]  w_dividend;
    logic [DVR_W-1:0]  w_divisor;
    logic [DIV_W-1:0]  w_quot;
    logic              w_div_done;
    logic [CNT_W-1:0]  w_at;
    logic [CALC_W-1:0] w_tm_wal;
    logic [CALC_W-1:0] w_tm_long;
    logic [TM_W-1:0]   w_tm;

    always_comb begin
        w_wt    = base_weight(i_word.base_char);
        w_is_gc = (i_word.base_char == CH_C) || (i_word.base_char == CH_G);
        w_mw    = r_mw_acc - MW_CORR;
    end

    // counting, one word a cycle while not busy; a base past the limit only raises the flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_total  <= '0;
            r_cnt_gc <= '0;
            r_mw_acc <= '0;
            r_ovf    <= 1'b0;
        end else if (i_take && (w_wt != '0)) begin
            if (r_total == MAX_BASES) begin
                r_ovf <= 1'b1;
            end else begin
                r_total  <= r_total + 1'b1;
                r_cnt_gc <= r_cnt_gc + CNT_W'(w_is_gc);
                r_mw_acc <= r_mw_acc + MW_W'(w_wt);
            end
        end
    end

    always_comb begin
        w_dividend = '0;
        w_divisor  = '0;
        unique case (i_cmd.div_sel)
            DIV_GC: begin
                w_dividend = DIV_W'(r_cnt_gc) * GC_SCALE;
                w_divisor  = DVR_W'(r_total);
            end
            DIV_TM: begin
                w_dividend = TM_NUM;
                w_divisor  = DVR_W'(r_total);
            end
            DIV_OD: begin
                w_dividend = OD_NUM;
                w_divisor  = w_mw;
            end
            default: begin
                w_dividend = '0;
                w_divisor  = '0;
            end
        endcase
    end

    otm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            case (i_cmd.div_sel)
                DIV_GC:  r_gc_pct <= w_quot[GC_W-1:0];
                DIV_TM:  r_tm_q   <= w_quot[TMQ_W-1:0];
                DIV_OD:  r_od     <= w_quot[OD_W-1:0];
                default: ;
            endcase
        end
    end

    // Tm: zero below 14 bases, Wallace rule from 14 up to 20 bases, GC-based formula above
    always_comb begin
        w_at      = r_total - r_cnt_gc;
        w_tm_wal  = (CALC_W'({r_cnt_gc, 2'b00}) + CALC_W'({w_at, 1'b0})) * WAL_SCALE;
        w_tm_long = CALC_W'(r_gc_pct) * TM_SLOPE + TM_OFFSET - CALC_W'(r_tm_q);
        if (r_total < TM_MIN_BASES) begin
            w_tm = '0;
        end else if (r_total <= TM_WAL_MAX) begin
            w_tm = w_tm_wal[TM_W-1:0];
        end else begin
            w_tm = w_tm_long[TM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_total == '0) begin
                r_word.empty_seq  <= 1'b1;
                r_word.overflow   <= 1'b0;
                r_word.base_count <= '0;
                r_word.gc_percent <= '0;
                r_word.tm_centi   <= '0;
                r_word.mol_weight <= '0;
                r_word.od_amount  <= '0;
            end else begin
                r_word.empty_seq  <= 1'b0;
                r_word.overflow   <= r_ovf;
                r_word.base_count <= r_total;
                r_word.gc_percent <= r_gc_pct;
                r_word.tm_centi   <= w_tm;
                r_word.mol_weight <= w_mw;
                r_word.od_amount  <= r_od;
            end
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.empty    = (r_total == '0);
    assign o_done          = r_done;
    assign o_word          = r_word;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("result strobe held longer than one cycle");

    a_gc_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_gc <= r_total) else $error("GC count exceeds base count");

endmodule

// ----- design/otm_ctrl.sv -----
// Controller: sequences the three divisions (skipped if empty) and the result load after the last word.
module otm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_last,
    input  otm_pkg::t_dp_stat i_stat,
    output otm_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import otm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GC,
        S_TM,
        S_OD,
        S_FIN
    } t_state;

    t_state  r_state;
    t_dp_cmd r_cmd;
    logic    r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_busy          <= 1'b0;
            r_cmd.div_start <= 1'b0;
            r_cmd.div_sel   <= DIV_GC;
            r_cmd.finish    <= 1'b0;
        end else begin
            r_cmd.div_start <= 1'b0;
            r_cmd.finish    <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_take && i_last) begin
                        r_state <= S_CHECK;
                        r_busy  <= 1'b1;
                    end
                end
                S_CHECK: begin
                    // counts now include the last word
                    if (i_stat.empty) begin
                        r_state      <= S_FIN;
                        r_cmd.finish <= 1'b1;
                    end else begin
                        r_state         <= S_GC;
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= DIV_GC;
                    end
                end
                S_GC: begin
                    if (i_stat.div_done) begin
                        r_state         <= S_TM;
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= DIV_TM;
                    end
                end
                S_TM: begin
                    if (i_stat.div_done) begin
                        r_state         <= S_OD;
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_sel   <= DIV_OD;
                    end
                end
                S_OD: begin
                    if (i_stat.div_done) begin
                        r_state      <= S_FIN;
                        r_cmd.finish <= 1'b1;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd  = r_cmd;
    assign o_busy = r_busy;

    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.div_start |=> !r_cmd.div_start) else $error("divider start held");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.finish |-> r_busy) else $error("result load while not busy");

endmodule

// ----- design/oligo_tm_mw_calculator.sv -----
// Every word is counted as it is accepted, one word per cycle while busy is low.
// After the last word, the GC, Tm and OD divisions run on the shared bit-serial
// divider, 25 steps each; then result and strobe load, with no divisions if empty.
// busy is high from the last word until the result is loaded; results cannot stall.
// Synchronous active-low reset clears the counters, flags and controller.
// Top level of the oligo melting temperature / molecular weight calculator.
module oligo_tm_mw_calculator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  otm_pkg::t_in_word  i_word,
    output logic               o_done,
    output otm_pkg::t_out_word o_word
);
    import otm_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;
    logic     w_take;

    assign w_take = start && !w_busy;
    assign busy   = w_busy;

    otm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_last  (i_word.is_last),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    otm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_word  (i_word),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_done  (o_done),
        .o_word  (o_word)
    );

endmodule
